@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the burst generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition c must hold in the same cycle as a.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);

// The condition c must hold in the cycle after a.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);

`endif

@@ rtl/core/fnb_pkg.sv @@
// Types, constants and helper functions of the filtered noise burst generator.
`timescale 1ns / 1ps

package fnb_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int INDEX_W   = 17;
	localparam int DIV_NUM_W = 33;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_STEPS = 17;
	localparam int LOG_STEPS = 16;
	localparam int POLY_STEPS = 3;

	localparam logic [31:0] NOISE_SEED = 32'h0123_4567;
	localparam int XS_A = 13;
	localparam int XS_B = 17;
	localparam int XS_C = 5;

	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
	localparam logic [17:0] POLY_SEED = 18'd5155;
	localparam logic [49:0] ROUND_HALF = 50'd1 << 25;

	localparam logic [15:0] START_RESET  = 16'd0;
	localparam logic [15:0] LENGTH_RESET = 16'd6174;
	localparam logic [15:0] AMP_RESET    = 16'd32768;
	localparam logic [11:0] DECAY_RESET  = 12'd768;
	localparam logic [5:0]  PASSES_RESET = 6'd2;
	localparam logic [15:0] ATTACK_RESET = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_OFFSET   = 3'd0,
		CFG_BURST_LENGTH   = 3'd1,
		CFG_AMPLITUDE      = 3'd2,
		CFG_DECAY_POWER    = 3'd3,
		CFG_LOWPASS_PASSES = 3'd4,
		CFG_ATTACK_LENGTH  = 3'd5
	} cfg_reg_t;

	// One word travelling along the averaging chain.
	typedef struct packed {
		logic                       vld;
		logic signed [SAMPLE_W-1:0] x;
	} fnb_tok_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [15:0]          den;
	} fnb_div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quo;
	} fnb_div_rsp_t;

	function automatic logic [31:0] xorshift32(input logic [31:0] s);
		logic [31:0] v;
		v = s;
		v = v ^ (v << XS_A);
		v = v ^ (v >> XS_B);
		v = v ^ (v << XS_C);
		return v;
	endfunction

	// Additive terms of the Horner steps of the exp2 cubic.
	function automatic logic [17:0] poly_coef(input logic [1:0] step);
		logic [17:0] c;
		unique case (step)
			2'd0: c = 18'd14822;
			2'd1: c = 18'd45559;
			2'd2: c = 18'd65536;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/core/fnb_if.sv @@
// Channel interfaces of the filtered noise burst generator.
`timescale 1ns / 1ps

interface fnb_in_if import fnb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] base_sample;
	logic                       restart;

	modport source (output valid, output base_sample, output restart, input ready);
	modport sink (input valid, input base_sample, input restart, output ready);
endinterface

interface fnb_out_if import fnb_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       in_burst;

	modport source (output valid, output mixed_sample, output in_burst, input ready);
	modport sink (input valid, input mixed_sample, input in_burst, output ready);
endinterface

interface fnb_cfg_if import fnb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/fnb_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit 17 bits.
`timescale 1ns / 1ps

module fnb_div import fnb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  fnb_div_req_t req,
	output fnb_div_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic [15:0]        den_q;
	logic [15:0]        rem_q;
	logic [DIV_Q_W-1:0] acc_q;

	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	// The low numerator bits shift out of acc_q while quotient bits shift in.
	always_comb begin
		trial = {rem_q, acc_q[DIV_Q_W-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				den_q  <= req.den;
				rem_q  <= req.num[DIV_NUM_W-1:DIV_Q_W];
				acc_q  <= req.num[DIV_Q_W-1:0];
			end else if (busy_q) begin
				rem_q <= fits ? diff[15:0] : trial[15:0];
				acc_q <= {acc_q[DIV_Q_W-2:0], fits};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;

endmodule

@@ rtl/core/fnb_cell.sv @@
// One averaging stage: holds its delay word and passes the averaged word on, or the word untouched when not in use.
`timescale 1ns / 1ps

module fnb_cell import fnb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     clear,
	input  logic     en,
	input  fnb_tok_t tok_in,
	output fnb_tok_t tok_out
);

	logic signed [SAMPLE_W-1:0] d_q;
	fnb_tok_t                   tok_q;
	logic signed [SAMPLE_W:0]   pair_sum;

	assign pair_sum = (SAMPLE_W+1)'($signed(tok_in.x)) + (SAMPLE_W+1)'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q   <= '0;
			tok_q <= '0;
		end else begin
			tok_q.vld <= tok_in.vld;
			if (clear) begin
				d_q <= '0;
			end else if (tok_in.vld && en) begin
				d_q <= tok_in.x;
			end
			// A stage that is not in use hands the word on untouched.
			if (tok_in.vld) begin
				tok_q.x <= en ? pair_sum[SAMPLE_W:1] : tok_in.x;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

@@ rtl/core/fnb_chain.sv @@
// Row of averaging cells; a word moves one cell per cycle.
`timescale 1ns / 1ps

module fnb_chain import fnb_pkg::*; #(
	parameter int MAX_PASSES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clear,
	input  logic [5:0] passes,
	input  fnb_tok_t   tok_in,
	output fnb_tok_t   tok_out
);

	fnb_tok_t tok [MAX_PASSES+1];

	assign tok[0] = tok_in;

	for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
		fnb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clear   (clear),
			.en      (7'(s) < {1'b0, passes}),
			.tok_in  (tok[s]),
			.tok_out (tok[s+1])
		);
	end

	assign tok_out = tok[MAX_PASSES];

endmodule

@@ rtl/core/filtered_noise_burst_generator.sv @@
// Top level of the filtered noise burst generator.
// Usage: one word on item per audio sample tick, carrying the existing mix
// sample and a restart flag; one word on result for each, carrying the
// mixed sample and an in-burst flag. Six registers are written over cfg
// (index 0 start offset up to 5 attack length); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Items are handled one at a time. A sample outside the burst window goes
// from the window check straight to the output register; inside the window
// it passes the shared divider, the 16 squaring steps of the log and the
// trip through the row of MAX_PASSES averaging cells, and the divider once
// more during the attack ramp. The result sits in an output register, so
// the next item is taken once it is there, even while the receiver stalls;
// a finished item waits only if that register is full. Reset loads the
// register defaults, seeds the noise generator, clears the sample index
// and all stage delays. Restart clears index and delays only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module filtered_noise_burst_generator import fnb_pkg::*; #(
	parameter int MAX_PASSES = 32
) (
	input  logic clk,
	input  logic arst_n,
	fnb_in_if.sink    item,
	fnb_out_if.source result,
	fnb_cfg_if.sink   cfg
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_WIN, ST_DIV1, ST_LOG, ST_EXPN, ST_POLY, ST_ENV, ST_ATT,
		ST_DIV2, ST_AMP, ST_SCALE, ST_ROUND, ST_CHAIN, ST_FIN
	} state_t;

	// Configuration registers.
	logic [15:0] cfg_start_q;
	logic [15:0] cfg_len_q;
	logic [15:0] cfg_amp_q;
	logic [11:0] cfg_decay_q;
	logic [5:0]  cfg_passes_q;
	logic [15:0] cfg_attack_q;

	state_t                     state_q;
	logic [INDEX_W-1:0]         index_q;
	logic [31:0]                noise_q;
	logic signed [SAMPLE_W-1:0] base_q;
	logic                       act_q;
	logic [15:0]                i_q;
	logic [16:0]                m_q;
	logic [4:0]                 ipart_q;
	logic [15:0]                frac_q;
	logic [3:0]                 step_q;
	logic [9:0]                 k_q;
	logic [16:0]                u_q;
	logic [17:0]                acc_q;
	logic [16:0]                env_q;
	logic                       sign_q;
	logic [31:0]                p1_q;
	logic [48:0]                p2_q;
	logic signed [SAMPLE_W-1:0] x_q;
	fnb_div_req_t               div_req_q;
	fnb_tok_t                   chain_in_q;
	logic                       out_vld_q;
	logic signed [SAMPLE_W-1:0] out_mixed_q;
	logic                       out_burst_q;

	fnb_div_rsp_t div_rsp;
	fnb_tok_t     chain_out;
	logic         in_acc;
	logic         chain_clear;

	logic [INDEX_W-1:0] win_end;
	logic [INDEX_W-1:0] win_off;
	logic               win_hit;
	logic [15:0]        rest_len;
	logic [4:0]         lead_e;
	logic [16:0]        norm_m;
	logic [33:0]        log_sq;
	logic [17:0]        log_t;
	logic [20:0]        lg;
	logic [33:0]        exp_prod;
	logic [34:0]        poly_prod;
	logic [15:0]        att;
	logic [31:0]        noise_nxt;
	logic [15:0]        noise_mag;
	logic [49:0]        round_sum;
	logic [23:0]        round_mag;
	logic signed [SAMPLE_W:0] mix_sum;
	logic signed [SAMPLE_W-1:0] mix_sat;

	assign in_acc      = item.valid && item.ready;
	assign chain_clear = in_acc && item.restart;

	always_comb begin
		win_end  = INDEX_W'(cfg_start_q) + INDEX_W'(cfg_len_q);
		win_off  = index_q - INDEX_W'(cfg_start_q);
		win_hit  = (cfg_len_q != '0) && (index_q >= INDEX_W'(cfg_start_q)) &&
			(index_q < win_end);
		rest_len = cfg_len_q - win_off[15:0];

		// Leading one of the ratio, then normalise it to [1, 2) in Q16.
		lead_e = '0;
		for (int b = 0; b < DIV_Q_W; b++) begin
			if (div_rsp.quo[b]) begin
				lead_e = 5'(b);
			end
		end
		norm_m = div_rsp.quo << (5'd16 - lead_e);

		log_sq   = 34'(m_q) * 34'(m_q);
		log_t    = log_sq[33:16];
		lg       = {ipart_q, 16'b0} - 21'(frac_q);
		exp_prod = 34'(cfg_decay_q) * 34'(lg) + 34'd128;
		poly_prod = 35'(acc_q) * 35'(u_q);
		att      = (cfg_attack_q < cfg_len_q) ? cfg_attack_q : cfg_len_q;

		noise_nxt = xorshift32(noise_q);
		noise_mag = noise_nxt[15] ? {1'b0, noise_nxt[14:0]} :
			16'(17'h10000 - 17'(noise_nxt[15:0]) - 17'h8000);

		round_sum = 50'(p2_q) + ROUND_HALF;
		round_mag = round_sum[49:26];

		mix_sum = (SAMPLE_W+1)'(base_q) + (SAMPLE_W+1)'(x_q);
		if (mix_sum[SAMPLE_W] != mix_sum[SAMPLE_W-1]) begin
			mix_sat = mix_sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} :
				{1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			mix_sat = mix_sum[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q  <= START_RESET;
			cfg_len_q    <= LENGTH_RESET;
			cfg_amp_q    <= AMP_RESET;
			cfg_decay_q  <= DECAY_RESET;
			cfg_passes_q <= PASSES_RESET;
			cfg_attack_q <= ATTACK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_START_OFFSET:   cfg_start_q  <= cfg.data;
				CFG_BURST_LENGTH:   cfg_len_q    <= cfg.data;
				CFG_AMPLITUDE:      cfg_amp_q    <= cfg.data;
				CFG_DECAY_POWER:    cfg_decay_q  <= cfg.data[11:0];
				CFG_LOWPASS_PASSES: cfg_passes_q <= cfg.data[5:0];
				CFG_ATTACK_LENGTH:  cfg_attack_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			index_q     <= '0;
			noise_q     <= NOISE_SEED;
			base_q      <= '0;
			act_q       <= 1'b0;
			i_q         <= '0;
			m_q         <= '0;
			ipart_q     <= '0;
			frac_q      <= '0;
			step_q      <= '0;
			k_q         <= '0;
			u_q         <= '0;
			acc_q       <= '0;
			env_q       <= '0;
			sign_q      <= 1'b0;
			p1_q        <= '0;
			p2_q        <= '0;
			x_q         <= '0;
			div_req_q   <= '0;
			chain_in_q  <= '0;
			out_vld_q   <= 1'b0;
			out_mixed_q <= '0;
			out_burst_q <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			chain_in_q.vld  <= 1'b0;
			if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						base_q <= item.base_sample;
						if (item.restart) begin
							index_q <= '0;
						end
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					act_q <= win_hit;
					if (index_q != INDEX_MAX) begin
						index_q <= index_q + 1'b1;
					end
					if (win_hit) begin
						i_q       <= win_off[15:0];
						div_req_q <= '{start: 1'b1, num: {1'b0, rest_len, 16'b0},
							den: cfg_len_q};
						state_q   <= ST_DIV1;
					end else begin
						x_q     <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						m_q     <= norm_m;
						ipart_q <= 5'd16 - lead_e;
						frac_q  <= '0;
						step_q  <= '0;
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					// Square the mantissa; a result of two or more yields a one bit.
					frac_q <= {frac_q[14:0], log_t[17]};
					m_q    <= log_t[17] ? log_t[17:1] : log_t[16:0];
					step_q <= step_q + 4'd1;
					if (step_q == 4'(LOG_STEPS - 1)) begin
						state_q <= ST_EXPN;
					end
				end
				ST_EXPN: begin
					k_q     <= exp_prod[33:24];
					u_q     <= 17'h10000 - 17'(exp_prod[23:8]);
					acc_q   <= POLY_SEED;
					step_q  <= '0;
					state_q <= ST_POLY;
				end
				ST_POLY: begin
					acc_q  <= 18'(19'(poly_coef(step_q[1:0])) + poly_prod[34:16]);
					step_q <= step_q + 4'd1;
					if (step_q == 4'(POLY_STEPS - 1)) begin
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					env_q   <= (k_q < 10'd16) ?
						17'(acc_q >> (5'd1 + {1'b0, k_q[3:0]})) : '0;
					state_q <= ST_ATT;
				end
				ST_ATT: begin
					if (i_q < att) begin
						div_req_q <= '{start: 1'b1, num: 33'(env_q) * 33'(i_q), den: att};
						state_q   <= ST_DIV2;
					end else begin
						state_q <= ST_AMP;
					end
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						env_q   <= div_rsp.quo;
						state_q <= ST_AMP;
					end
				end
				ST_AMP: begin
					noise_q <= noise_nxt;
					sign_q  <= !noise_nxt[15];
					p1_q    <= 32'(noise_mag) * 32'(cfg_amp_q);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					p2_q    <= 49'(p1_q) * 49'(env_q);
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					chain_in_q.vld <= 1'b1;
					chain_in_q.x   <= sign_q ? -$signed(round_mag) : $signed(round_mag);
					state_q        <= ST_CHAIN;
				end
				ST_CHAIN: begin
					if (chain_out.vld) begin
						x_q     <= chain_out.x;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_vld_q || result.ready) begin
						out_vld_q   <= 1'b1;
						out_mixed_q <= mix_sat;
						out_burst_q <= act_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	fnb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	fnb_chain #(
		.MAX_PASSES (MAX_PASSES)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (chain_clear),
		.passes  (cfg_passes_q),
		.tok_in  (chain_in_q),
		.tok_out (chain_out)
	);

	assign item.ready          = (state_q == ST_IDLE);
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_vld_q;
	assign result.mixed_sample = out_mixed_q;
	assign result.in_burst     = out_burst_q;

	`ASSERT_IMPLIES(a_chain_word_expected, clk, arst_n, chain_out.vld, state_q == ST_CHAIN, "chain word arrived outside the chain wait")
	`ASSERT_IMPLIES(a_div_done_expected, clk, arst_n, div_rsp.done, state_q == ST_DIV1 || state_q == ST_DIV2, "quotient arrived outside a divide wait")
	`ASSERT_NEXT(a_accept_to_window, clk, arst_n, in_acc, state_q == ST_WIN && !chain_in_q.vld, "accepted word did not move to the window check")

endmodule
